// ===== hw/rtl/bdeq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdeq_pkg;

  // Width of one stored word
  localparam int DATA_W = 32;
  // Width of the request code and the status code
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;
  // Width of the occupancy port
  localparam int OCC_W  = 7;

  // Request codes; unused codes behave as a peek
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_PEEK       = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What every cell of one chain does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,  // keep the word
    OP_GROW   = 2'd1,  // take the word from the neighbor nearer the chain head
    OP_SHRINK = 2'd2,  // take the word from the neighbor farther from the head
    OP_APPEND = 2'd3   // the cell at the current count takes the pushed word
  } chain_op_e;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    chain_op_e               fwd_op;  // chain with the front word at cell 0
    chain_op_e               rev_op;  // chain with the rear word at cell 0
    logic signed [DATA_W-1:0] value;  // pushed word
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bdeq_cell.sv =====
// One storage cell of the deque: a word of the front-first chain and a word
// of the rear-first chain.
`timescale 1ns / 1ps

module bdeq_cell (
  input  logic                              clk_i,
  input  bdeq_pkg::cell_ctrl_t              ctrl_i,
  input  logic                              at_count_i,
  input  logic signed [bdeq_pkg::DATA_W-1:0] fwd_near_i,
  input  logic signed [bdeq_pkg::DATA_W-1:0] fwd_far_i,
  input  logic signed [bdeq_pkg::DATA_W-1:0] rev_near_i,
  input  logic signed [bdeq_pkg::DATA_W-1:0] rev_far_i,
  output logic signed [bdeq_pkg::DATA_W-1:0] fwd_o,
  output logic signed [bdeq_pkg::DATA_W-1:0] rev_o
);
  import bdeq_pkg::*;

  logic signed [DATA_W-1:0] fwd_q, fwd_d;
  logic signed [DATA_W-1:0] rev_q, rev_d;

  // Front-first chain word
  always_comb begin
    unique case (ctrl_i.fwd_op)
      OP_HOLD:   fwd_d = fwd_q;
      OP_GROW:   fwd_d = fwd_near_i;
      OP_SHRINK: fwd_d = fwd_far_i;
      OP_APPEND: fwd_d = at_count_i ? ctrl_i.value : fwd_q;
      default:   fwd_d = fwd_q;
    endcase
  end

  // Rear-first chain word
  always_comb begin
    unique case (ctrl_i.rev_op)
      OP_HOLD:   rev_d = rev_q;
      OP_GROW:   rev_d = rev_near_i;
      OP_SHRINK: rev_d = rev_far_i;
      OP_APPEND: rev_d = at_count_i ? ctrl_i.value : rev_q;
      default:   rev_d = rev_q;
    endcase
  end

  // Payload only; dead words are never shown
  always_ff @(posedge clk_i) begin
    fwd_q <= fwd_d;
    rev_q <= rev_d;
  end

  assign fwd_o = fwd_q;
  assign rev_o = rev_q;

endmodule

// ===== hw/rtl/bounded_double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue built from a chain of cells.
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit words, CAPACITY entries.
// Input channel: req_type_i / push_value_i, qualified by in_valid_i, held
// off by in_stall_o. Output channel: one result word per request on the
// status/value/flag ports, qualified by out_valid_o, held off by out_stall_i.
// Storage is a row of CAPACITY cells holding two mirrored chains: one keeps
// the front word in cell 0, the other keeps the rear word in cell 0. A push
// shifts one chain toward the far end and appends at the count in the other;
// a pop shifts one chain toward cell 0. Every cell moves in the same cycle.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while no result is held by a stall;
// each request is one set of cell updates, and the output register takes the
// next result as the current one leaves.
// Reset clears the count and the output valid; the deque starts empty.
// While the receiver stalls a valid result, the result holds, the cells hold,
// and in_stall_o is raised so no new request is taken.

module bounded_double_ended_queue_top #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bdeq_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [bdeq_pkg::DATA_W-1:0]  push_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bdeq_pkg::STAT_W-1:0]         status_o,
  output logic signed [bdeq_pkg::DATA_W-1:0]  popped_value_o,
  output logic signed [bdeq_pkg::DATA_W-1:0]  front_value_o,
  output logic signed [bdeq_pkg::DATA_W-1:0]  rear_value_o,
  output logic                               is_empty_o,
  output logic                               is_full_o,
  output logic [bdeq_pkg::OCC_W-1:0]          occupancy_o
);
  import bdeq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     empty, full;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  cell_ctrl_t               ctrl;
  logic [CAPACITY-1:0]      at_count;
  logic signed [DATA_W-1:0] fwd [CAPACITY];
  logic signed [DATA_W-1:0] rev [CAPACITY];
  logic [CNT_W+OCC_W-1:0]   count_ext;

  // Handshake: a held result blocks new requests
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign empty = (count_q == '0);
  assign full  = (count_q == CNT_W'(CAPACITY));

  // Request decode into chain operations
  always_comb begin
    ctrl.fwd_op = OP_HOLD;
    ctrl.rev_op = OP_HOLD;
    ctrl.value  = push_value_i;
    count_d     = count_q;
    status_d    = ST_DONE;
    popped_d    = '0;
    unique case (req_type_i)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.fwd_op = OP_GROW;
          ctrl.rev_op = OP_APPEND;
          count_d     = count_q + CNT_W'(1);
        end
      end
      REQ_PUSH_REAR: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.fwd_op = OP_APPEND;
          ctrl.rev_op = OP_GROW;
          count_d     = count_q + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.fwd_op = OP_SHRINK;
          popped_d    = fwd[0];
          count_d     = count_q - CNT_W'(1);
        end
      end
      REQ_POP_REAR: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.rev_op = OP_SHRINK;
          popped_d    = rev[0];
          count_d     = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
    if (!accept) begin
      ctrl.fwd_op = OP_HOLD;
      ctrl.rev_op = OP_HOLD;
    end
  end

  // Row of cells; each sees only its two neighbors, cell 0 sees the pushed word as its near one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] fwd_near, fwd_far, rev_near, rev_far;

    assign at_count[i] = (count_q == CNT_W'(i));

    if (i == 0) begin : g_head
      assign fwd_near = push_value_i;
      assign rev_near = push_value_i;
    end else begin : g_inner_near
      assign fwd_near = fwd[i-1];
      assign rev_near = rev[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign fwd_far = '0;
      assign rev_far = '0;
    end else begin : g_inner_far
      assign fwd_far = fwd[i+1];
      assign rev_far = rev[i+1];
    end

    bdeq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .at_count_i (at_count[i]),
      .fwd_near_i (fwd_near),
      .fwd_far_i  (fwd_far),
      .rev_near_i (rev_near),
      .rev_far_i  (rev_far),
      .fwd_o      (fwd[i]),
      .rev_o      (rev[i])
    );
  end

  // Count and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  // Front and rear come from cell 0 of each chain, flags from the count; they only move on accept
  assign count_ext      = {{OCC_W{1'b0}}, count_q};
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = empty ? '0 : fwd[0];
  assign rear_value_o   = empty ? '0 : rev[0];
  assign is_empty_o     = empty;
  assign is_full_o      = full;
  assign occupancy_o    = count_ext[OCC_W-1:0];

endmodule
